// ===== rtl/read_mark_sorted_list_core_macros.svh =====
// Assertion helpers; each expects clk and arst_n in the enclosing scope.
`ifndef READ_MARK_SORTED_LIST_CORE_MACROS_SVH
`define READ_MARK_SORTED_LIST_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define RMSL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("read mark list: assertion failed");

// Next-cycle implication, disabled during reset.
`define RMSL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("read mark list: assertion failed");

`endif

// ===== rtl/rmsl_pkg.sv =====
package rmsl_pkg;

	localparam int TIME_W    = 32;
	localparam int OP_W      = 2;
	localparam int COUNT_W   = 7;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [OP_W-1:0] {
		OP_MARK  = 2'd0,
		OP_QUERY = 2'd1,
		OP_RESET = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EXPIRY = 1'b0,
		REG_ENABLE = 1'b1
	} cfg_reg_t;

	// Per-cell control from the sequencer.
	typedef struct packed {
		logic valid;      // this cell holds a live entry
		logic prev_valid; // neighbor toward the head holds a live entry
		logic cmp;        // latch compare flags against the broadcast time
		logic mark;       // apply insert/shift
		logic load;       // load the broadcast time unconditionally
	} cell_ctl_t;

	// Compare flags handed to the next cell down the row.
	typedef struct packed {
		logic lt; // broadcast time below this entry
		logic gt; // broadcast time above this entry
	} cell_flags_t;

endpackage

// ===== rtl/read_mark_sorted_list_core.sv =====
// Read-mark list core: keeps up to MAX_ENTRIES read timestamps, newest first,
// in a row of compare-and-shift cells. When a request is accepted, each cell
// latches how the request time compares with its own entry; in the update
// state that follows, the cells insert, shift or stay put from their own flags
// and their neighbor's, and the result is registered. Raise start
// while busy is low; done pulses for exactly one cycle with is_unread,
// list_changed and entry_count valid, and the receiver cannot stall it. A new
// request is taken in the same cycle that done is shown. Configuration writes
// are always ready and belong in idle time only.
module read_mark_sorted_list_core #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [rmsl_pkg::OP_W-1:0]            operation,
	input  logic signed [rmsl_pkg::TIME_W-1:0]   item_time,
	output logic                                 done,
	output logic                                 is_unread,
	output logic                                 list_changed,
	output logic [rmsl_pkg::COUNT_W-1:0]         entry_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [rmsl_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [rmsl_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import rmsl_pkg::*;

	`include "read_mark_sorted_list_core_macros.svh"

	localparam int CW = $clog2(MAX_ENTRIES + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_UPD  = 2'b10
	} state_t;

	state_t                   state_q;
	logic                     accept;
	logic [OP_W-1:0]          op_q;
	logic signed [TIME_W-1:0] t_q;
	logic signed [TIME_W-1:0] t_bcast;
	logic signed [TIME_W-1:0] limit_q;
	logic                     enable_q;
	logic [CW-1:0]            count_q;
	logic [CW-1:0]            count_nxt;
	logic                     done_q;
	logic                     unread_q;
	logic                     changed_q;

	logic signed [TIME_W-1:0] entry_w [MAX_ENTRIES];
	cell_flags_t              flags_w [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]   ins_w;
	logic [MAX_ENTRIES-1:0]   qhit_w;
	logic [MAX_ENTRIES-1:0]   valid_w;
	logic [MAX_ENTRIES-1:0]   dup_w;

	logic in_upd;
	logic above_limit;
	logic single_older;
	logic mark_go;
	logic changed;
	logic unread;
	logic [CW+COUNT_W-1:0] count_wide;

	assign accept    = start && !busy;
	assign busy      = (state_q == ST_UPD);
	assign in_upd    = (state_q == ST_UPD);
	assign cfg_ready = 1'b1;

	// Compare against the live input on the accept edge, then update from the
	// held copy.
	assign t_bcast = in_upd ? t_q : item_time;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q  <= '0;
			enable_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_EXPIRY: limit_q  <= cfg_data[TIME_W-1:0];
				REG_ENABLE: enable_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Row of cells. Cell 0 sees a virtual neighbor that is always above.
	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		cell_ctl_t                ctl;
		cell_flags_t              pflags;
		logic signed [TIME_W-1:0] pentry;

		assign valid_w[i] = (CW'(i) < count_q);
		// live entry equal to the request time
		assign dup_w[i]   = valid_w[i] && !flags_w[i].lt && !flags_w[i].gt;

		if (i == 0) begin : g_head
			assign pflags         = '{lt: 1'b1, gt: 1'b0};
			assign pentry         = t_bcast;
			assign ctl.prev_valid = 1'b1;
			assign ctl.load       = in_upd && (op_q == OP_RESET);
		end else begin : g_body
			assign pflags         = flags_w[i-1];
			assign pentry         = entry_w[i-1];
			assign ctl.prev_valid = valid_w[i-1];
			assign ctl.load       = 1'b0;
		end

		assign ctl.valid = valid_w[i];
		assign ctl.cmp   = accept;
		assign ctl.mark  = mark_go;

		rmsl_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.t_bcast    (t_bcast),
			.prev_entry (pentry),
			.prev_flags (pflags),
			.entry      (entry_w[i]),
			.flags      (flags_w[i]),
			.ins        (ins_w[i]),
			.qhit       (qhit_w[i])
		);
	end

	// Decide the request from the latched flags.
	always_comb begin
		above_limit  = t_q > limit_q;
		// a one-entry list drops an older time instead of appending it
		single_older = (count_q == CW'(1)) && flags_w[0].lt;
		// a time already in the list leaves every cell alone
		mark_go      = in_upd && (op_q == OP_MARK) && enable_q && above_limit
			&& !single_older && !(|dup_w);
		changed      = 1'b0;
		unread       = 1'b0;
		count_nxt    = count_q;
		case (op_t'(op_q))
			OP_MARK: begin
				changed = mark_go && (|ins_w);
				if (changed && (count_q < CW'(MAX_ENTRIES))) begin
					count_nxt = count_q + CW'(1);
				end
			end
			OP_QUERY: begin
				unread = above_limit && ((count_q == '0) || (|qhit_w));
			end
			OP_RESET: begin
				changed   = 1'b1;
				count_nxt = CW'(1);
			end
			default: ;
		endcase
	end

	// Sequencer and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_UPD;
					end
				end
				ST_UPD: begin
					count_q <= count_nxt;
					done_q  <= 1'b1;
					// a new request may be latched on the next accept
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload holds; no reset needed.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= operation;
			t_q  <= item_time;
		end
		if (in_upd) begin
			unread_q  <= unread;
			changed_q <= changed;
		end
	end

	assign count_wide   = (CW + COUNT_W)'(count_q);
	assign done         = done_q;
	assign is_unread    = unread_q;
	assign list_changed = changed_q;
	assign entry_count  = count_wide[COUNT_W-1:0];

	// The list never grows past the row.
	`RMSL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(MAX_ENTRIES))
	// A result follows every update state.
	`RMSL_ASSERT_NEXT(a_done_after_upd, in_upd, done)
	// A query never modifies the list, and a mark never reports unread.
	`RMSL_ASSERT_NOW(a_excl_flags, done, !(is_unread && list_changed))
	// A changed list is never empty afterwards.
	`RMSL_ASSERT_NOW(a_changed_nonempty, done && list_changed, count_q != '0)
	// Accepted requests always enter the update cycle.
	`RMSL_ASSERT_NEXT(a_accept_busy, accept, busy)

endmodule

// ===== rtl/rmsl_cell.sv =====
module rmsl_cell (
	input  logic                             clk,
	input  rmsl_pkg::cell_ctl_t              ctl,
	input  logic signed [rmsl_pkg::TIME_W-1:0] t_bcast,
	input  logic signed [rmsl_pkg::TIME_W-1:0] prev_entry,
	input  rmsl_pkg::cell_flags_t            prev_flags,
	output logic signed [rmsl_pkg::TIME_W-1:0] entry,
	output rmsl_pkg::cell_flags_t            flags,
	output logic                             ins,
	output logic                             qhit
);
	import rmsl_pkg::*;

	logic signed [TIME_W-1:0] entry_q;
	cell_flags_t              flags_q;
	logic                     shift;

	// Insert point: time above this entry (or slot empty) and below the neighbor.
	assign ins   = (!ctl.valid || flags_q.gt) && ctl.prev_valid && prev_flags.lt;
	assign qhit  = ctl.valid && flags_q.gt && ctl.prev_valid && prev_flags.lt;
	assign shift = ctl.prev_valid && prev_flags.gt;

	always_ff @(posedge clk) begin
		if (ctl.cmp) begin
			flags_q.gt <= t_bcast > entry_q;
			flags_q.lt <= t_bcast < entry_q;
		end
		if (ctl.load) begin
			entry_q <= t_bcast;
		end else if (ctl.mark) begin
			if (ins) begin
				entry_q <= t_bcast;
			end else if (shift) begin
				entry_q <= prev_entry;
			end
		end
	end

	assign entry = entry_q;
	assign flags = flags_q;

endmodule
